>>> sv/e2c_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_pkg
// Constants and types for the epoch seconds to calendar decoder.
// ----------------------------------------------------------------------------
package e2c_pkg;

    localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
    localparam logic [15:0] YEAR_SCALED   = 16'd36525;
    localparam logic [6:0]  DAY_SCALE     = 7'd100;
    localparam logic [8:0]  TENTHS_MONTH  = 9'd306;
    localparam logic [2:0]  WEEK_DAYS     = 3'd7;

    // scaled day count plus year rounding: 2 * 36525 - 5950 + 75
    localparam logic [21:0] YEAR_BIAS     = 22'd67175;
    // day rounding minus year rounding
    localparam logic [15:0] DAY_BIAS      = 16'd100;
    // 5 + epoch shift / 100
    localparam logic [14:0] WEEK_BIAS     = 15'd676;
    localparam logic [11:0] TENTHS_BIAS   = 12'd6;
    localparam logic [10:0] BASE_YEAR     = 11'd1968;
    localparam logic [3:0]  MONTH_WRAP    = 4'd10;

    // floor(2^shift / divisor); quotient is low by at most one
    localparam logic [14:0] RECIP_DAY     = 15'd24855;   // shift 31
    localparam logic [5:0]  RECIP_HOUR    = 6'd36;       // shift 17
    localparam logic [6:0]  RECIP_YEAR    = 7'd114;      // shift 22
    localparam logic [12:0] RECIP_WEEK    = 13'd4681;    // shift 15
    localparam logic [6:0]  RECIP_MIN     = 7'd68;       // shift 12
    localparam logic [9:0]  RECIP_CENT    = 10'd655;     // shift 16
    localparam logic [3:0]  RECIP_MONTH   = 4'd13;       // shift 12
    // exact divide by ten below 1029: (x * 205) >> 11
    localparam logic [7:0]  RECIP_TEN     = 8'd205;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [6:0] year_idx;
        logic [2:0] weekday;
    } e2c_carry_t;

endpackage
`default_nettype wire

>>> sv/e2c_divfix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_divfix
// Quotient fix-up for division by a constant: takes an estimate that is
// exact or one low, gives the exact quotient and remainder.
// ----------------------------------------------------------------------------
module e2c_divfix #(
    parameter int NW  = 31,
    parameter int QW  = 15,
    parameter int DIV = 86400
) (
    input  wire logic [NW-1:0]            num,
    input  wire logic [QW-1:0]            qest,
    output logic      [QW-1:0]            quo,
    output logic      [$clog2(DIV)-1:0]   rem
);

    localparam int RW = $clog2(DIV);
    localparam logic [NW-1:0] DIV_N = NW'(DIV);

    logic [NW-1:0] prod;
    logic [NW-1:0] diff;
    logic          fix;

    always_comb
    begin
        prod = NW'(qest) * DIV_N;
        diff = num - prod;
        fix  = (diff >= DIV_N);
        quo  = qest + QW'(fix);
        rem  = fix ? RW'(diff - DIV_N) : RW'(diff);
    end

endmodule
`default_nettype wire

>>> sv/epoch_seconds_to_calendar.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Decodes seconds since 1970-01-01 00:00:00 into time of day, date and
// day of week.
// ----------------------------------------------------------------------------
// Thirteen-stage pipeline that takes one word per cycle while s_tready is high
// and returns one word per input word. Every stage holds its own valid bit, so
// bubbles are squeezed out and s_tready stays high while any stage is free.
// Each division by a constant but the exact divide by ten is a registered
// reciprocal multiply followed by a one-step correction in the next stage;
// the chain days -> year -> day of year -> month -> day of month sets the
// depth. Only the low 31 bits of s_tdata are used; any value decodes to a
// date from 1970-01-01 to 2038-01-19.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar
    import e2c_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] epoch_seconds, [31] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [5:0] second_out, [11:6] minute_out, [16:12] hour_out,
    // [21:17] day_of_month, [25:22] month_out, [36:26] year_out,
    // [39:37] weekday_out
    output logic      [39:0] m_tdata
);

    localparam int NST = 13;

    logic [NST:1] v_reg;
    logic [NST:1] v_in;
    logic [NST:1] en;

    always_comb
    begin
        en[NST] = ~v_reg[NST] | m_tready;
        for (int k = NST - 1; k >= 1; k--)
        begin
            en[k] = ~v_reg[k] | en[k+1];
        end
        v_in = {v_reg[NST-1:1], s_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = v_reg[NST];

    // stage 1
    logic [30:0] t1_reg;
    logic [45:0] pday1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            t1_reg    <= s_tdata[30:0];
            pday1_reg <= 46'(s_tdata[30:0]) * 46'(RECIP_DAY);
        end
    end

    // stage 2: days and second of day
    logic [14:0] day2_next;
    logic [16:0] sod2_next;
    logic [14:0] day2_reg;
    logic [16:0] sod2_reg;

    e2c_divfix #(.NW(31), .QW(15), .DIV(86400)) u_div_day (
        .num  (t1_reg),
        .qest (pday1_reg[45:31]),
        .quo  (day2_next),
        .rem  (sod2_next)
    );

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            day2_reg <= day2_next;
            sod2_reg <= sod2_next;
        end
    end

    // stage 3
    logic [16:0] sod3_reg;
    logic [22:0] phr3_reg;
    logic [21:0] yn3_reg;
    logic [14:0] wk3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            sod3_reg <= sod2_reg;
            phr3_reg <= 23'(sod2_reg) * 23'(RECIP_HOUR);
            yn3_reg  <= 22'(day2_reg) * 22'(DAY_SCALE) + YEAR_BIAS;
            wk3_reg  <= day2_reg + WEEK_BIAS;
        end
    end

    // stage 4: hour
    logic [5:0]  hr4_next;
    logic [11:0] rs4_next;
    logic [4:0]  hr4_reg;
    logic [11:0] rs4_reg;
    logic [28:0] pyr4_reg;
    logic [27:0] pwk4_reg;
    logic [21:0] yn4_reg;
    logic [14:0] wk4_reg;

    e2c_divfix #(.NW(17), .QW(6), .DIV(3600)) u_div_hour (
        .num  (sod3_reg),
        .qest (phr3_reg[22:17]),
        .quo  (hr4_next),
        .rem  (rs4_next)
    );

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            hr4_reg  <= hr4_next[4:0];
            rs4_reg  <= rs4_next;
            pyr4_reg <= 29'(yn3_reg) * 29'(RECIP_YEAR);
            pwk4_reg <= 28'(wk3_reg) * 28'(RECIP_WEEK);
            yn4_reg  <= yn3_reg;
            wk4_reg  <= wk3_reg;
        end
    end

    // stage 5: year and weekday
    logic [6:0]  yr5_next;
    logic [15:0] yrem5_next;
    logic [2:0]  wd5_next;
    logic [6:0]  yr5_reg;
    logic [15:0] yrem5_reg;
    logic [2:0]  wd5_reg;
    logic [4:0]  hr5_reg;
    logic [11:0] rs5_reg;
    logic [18:0] pmin5_reg;

    e2c_divfix #(.NW(22), .QW(7), .DIV(36525)) u_div_year (
        .num  (yn4_reg),
        .qest (pyr4_reg[28:22]),
        .quo  (yr5_next),
        .rem  (yrem5_next)
    );

    e2c_divfix #(.NW(15), .QW(13), .DIV(7)) u_div_week (
        .num  (wk4_reg),
        .qest (pwk4_reg[27:15]),
        .quo  (),
        .rem  (wd5_next)
    );

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            yr5_reg   <= yr5_next;
            yrem5_reg <= yrem5_next;
            wd5_reg   <= wd5_next;
            hr5_reg   <= hr4_reg;
            rs5_reg   <= rs4_reg;
            pmin5_reg <= 19'(rs4_reg) * 19'(RECIP_MIN);
        end
    end

    // stage 6: minute and second
    logic [6:0]  min6_next;
    logic [5:0]  sec6_next;
    e2c_carry_t  c6_reg;
    logic [15:0] x6_reg;

    e2c_divfix #(.NW(12), .QW(7), .DIV(60)) u_div_min (
        .num  (rs5_reg),
        .qest (pmin5_reg[18:12]),
        .quo  (min6_next),
        .rem  (sec6_next)
    );

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            c6_reg.second   <= sec6_next;
            c6_reg.minute   <= min6_next[5:0];
            c6_reg.hour     <= hr5_reg;
            c6_reg.year_idx <= yr5_reg;
            c6_reg.weekday  <= wd5_reg;
            x6_reg          <= yrem5_reg + DAY_BIAS;
        end
    end

    // stage 7
    e2c_carry_t  c7_reg;
    logic [15:0] x7_reg;
    logic [25:0] pcent7_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            c7_reg     <= c6_reg;
            x7_reg     <= x6_reg;
            pcent7_reg <= 26'(x6_reg) * 26'(RECIP_CENT);
        end
    end

    // stage 8: day of March-based year
    logic [9:0] dd8_next;
    e2c_carry_t c8_reg;
    logic [9:0] dd8_reg;

    e2c_divfix #(.NW(16), .QW(10), .DIV(100)) u_div_cent (
        .num  (x7_reg),
        .qest (pcent7_reg[25:16]),
        .quo  (dd8_next),
        .rem  ()
    );

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            c8_reg  <= c7_reg;
            dd8_reg <= dd8_next;
        end
    end

    // stage 9: tenths of day less six
    e2c_carry_t  c9_reg;
    logic [11:0] tm9_reg;

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            c9_reg  <= c8_reg;
            tm9_reg <= 12'(dd8_reg) * 12'(4'd10) - TENTHS_BIAS;
        end
    end

    // stage 10
    e2c_carry_t  c10_reg;
    logic [11:0] tm10_reg;
    logic [15:0] pmon10_reg;

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            c10_reg    <= c9_reg;
            tm10_reg   <= tm9_reg;
            pmon10_reg <= 16'(tm9_reg) * 16'(RECIP_MONTH);
        end
    end

    // stage 11: month from March
    logic [3:0] mon11_next;
    logic [8:0] mr11_next;
    e2c_carry_t c11_reg;
    logic [3:0] mon11_reg;
    logic [8:0] mr11_reg;

    e2c_divfix #(.NW(12), .QW(4), .DIV(306)) u_div_month (
        .num  (tm10_reg),
        .qest (pmon10_reg[15:12]),
        .quo  (mon11_next),
        .rem  (mr11_next)
    );

    always_ff @(posedge clk)
    begin
        if (en[11])
        begin
            c11_reg   <= c10_reg;
            mon11_reg <= mon11_next;
            mr11_reg  <= mr11_next;
        end
    end

    // stage 12: calendar month and year
    logic        wrap12;
    e2c_carry_t  c12_reg;
    logic [16:0] pdom12_reg;
    logic [3:0]  mo12_reg;
    logic [10:0] year12_reg;

    assign wrap12 = (mon11_reg >= MONTH_WRAP);

    always_ff @(posedge clk)
    begin
        if (en[12])
        begin
            c12_reg    <= c11_reg;
            pdom12_reg <= 17'(mr11_reg) * 17'(RECIP_TEN);
            mo12_reg   <= wrap12 ? mon11_reg - 4'd9 : mon11_reg + 4'd3;
            year12_reg <= BASE_YEAR + 11'(c11_reg.year_idx) + 11'(wrap12);
        end
    end

    // stage 13: output word
    logic [4:0] dom13_next;

    assign dom13_next = 5'(pdom12_reg[16:11]) + 5'd1;

    always_ff @(posedge clk)
    begin
        if (en[13])
        begin
            m_tdata <= {c12_reg.weekday + 3'd1,
                        year12_reg,
                        mo12_reg,
                        dom13_next,
                        c12_reg.hour,
                        c12_reg.minute,
                        c12_reg.second};
        end
    end

endmodule
`default_nettype wire
